// ----- rtl/signed_decimal_ascii_formatter_defines.svh -----
// Assertion macros shared by the signed decimal ASCII formatter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SIGNED_DECIMAL_ASCII_FORMATTER_DEFINES_SVH
`define SIGNED_DECIMAL_ASCII_FORMATTER_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked at every rising edge, suspended while reset is asserted.
`define SDAF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("signed_decimal_ascii_formatter: assertion failed");
// Property checked at every rising edge, reset included.
`define SDAF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("signed_decimal_ascii_formatter: assertion failed");
`else
`define SDAF_ASSERT(label, clk, rst_n, prop)
`define SDAF_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- rtl/sdaf_pkg.sv -----
// Package for the signed decimal ASCII formatter: widths, character codes,
// the emitter state type and the converter-to-emitter hand-off type.
package sdaf_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned DIGITS  = 5;
  localparam int unsigned BCD_W   = 4 * DIGITS;
  localparam int unsigned STEP_W  = $clog2(VALUE_W);
  localparam int unsigned NDIG_W  = $clog2(DIGITS + 1);

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIGIT,
    ST_TAB
  } sdaf_state_e;

  typedef struct packed {
    logic               neg;
    logic [BCD_W-1:0]   digits;
  } sdaf_bcd_t;

endpackage

// ----- rtl/sdaf_if.sv -----
// Valid/ready channel interfaces of the signed decimal ASCII formatter.
// Depends on sdaf_pkg for the field widths.
interface sdaf_in_if import sdaf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sdaf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- rtl/sdaf_bcd.sv -----
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on sdaf_pkg, sdaf_if and the assertion macro header.
`include "signed_decimal_ascii_formatter_defines.svh"

module sdaf_bcd import sdaf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  sdaf_in_if.sink       in_i,
  output logic          bcd_valid_o,
  input  logic          bcd_ready_i,
  output sdaf_bcd_t     bcd_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [VALUE_W-1:0]  bin_q, bin_d;
  logic [BCD_W-1:0]    bcd_q, bcd_d;
  logic                neg_q, neg_d;
  logic [BCD_W-1:0]    adj;
  logic [VALUE_W-1:0]  mag;
  logic                take;

  // Magnitude of the two's-complement input; -32768 maps to 0x8000.
  assign mag  = in_i.value[VALUE_W-1] ? VALUE_W'(~in_i.value + 1'b1) : VALUE_W'(in_i.value);
  assign take = in_i.valid && in_i.ready;

  assign in_i.ready  = !busy_q && !done_q;
  assign bcd_valid_o = done_q;
  assign bcd_o       = '{neg: neg_q, digits: bcd_q};

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    neg_d  = neg_q;
    if (take) begin
      busy_d = 1'b1;
      step_d = '0;
      bin_d  = mag;
      bcd_d  = '0;
      neg_d  = in_i.value[VALUE_W-1];
    end else if (busy_q) begin
      bcd_d  = {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
      bin_d  = {bin_q[VALUE_W-2:0], 1'b0};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(VALUE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (done_q && bcd_ready_i) begin
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  `SDAF_ASSERT(a_busy_done_excl, clk_i, rst_ni, !(busy_q && done_q))
  `SDAF_ASSERT(a_done_after_last_step, clk_i, rst_ni,
    (busy_q && !take && step_q == STEP_W'(VALUE_W - 1)) |=> (done_q && !busy_q))
  `SDAF_ASSERT(a_digits_decimal, clk_i, rst_ni,
    done_q |-> (bcd_q[3:0] <= 4'd9 && bcd_q[7:4] <= 4'd9 && bcd_q[11:8] <= 4'd9
                && bcd_q[15:12] <= 4'd9 && bcd_q[19:16] <= 4'd9))

endmodule

// ----- rtl/sdaf_emit.sv -----
// Character emitter: sends sign, significant BCD digits and the closing tab,
// one character per transaction. Depends on sdaf_pkg, sdaf_if and the macros.
`include "signed_decimal_ascii_formatter_defines.svh"

module sdaf_emit import sdaf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          bcd_valid_i,
  output logic          bcd_ready_o,
  input  sdaf_bcd_t     bcd_i,
  sdaf_out_if.source    out_o
);

  sdaf_state_e         state_q, state_d;
  logic [BCD_W-1:0]    dig_q, dig_d;
  logic [NDIG_W-1:0]   cnt_q, cnt_d;
  logic                vld_q, vld_d;
  logic [7:0]          char_q, char_d;
  logic                last_q, last_d;
  logic                free;
  logic                take;
  logic                emit;
  logic                shift;
  logic [7:0]          emit_char;
  logic                emit_last;
  logic [NDIG_W-1:0]   ndig;
  logic [BCD_W-1:0]    aligned;

  assign free = !vld_q || out_o.ready;
  assign take = bcd_valid_i && bcd_ready_o;

  assign out_o.valid     = vld_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

  // Number of significant digits, at least one so that zero prints as '0'.
  always_comb begin
    if (bcd_i.digits[19:16] != 4'd0) begin
      ndig = NDIG_W'(5);
    end else if (bcd_i.digits[15:12] != 4'd0) begin
      ndig = NDIG_W'(4);
    end else if (bcd_i.digits[11:8] != 4'd0) begin
      ndig = NDIG_W'(3);
    end else if (bcd_i.digits[7:4] != 4'd0) begin
      ndig = NDIG_W'(2);
    end else begin
      ndig = NDIG_W'(1);
    end
  end

  // Move the most significant non-zero digit to the top of the shift register.
  always_comb begin
    case (ndig)
      NDIG_W'(5): aligned = bcd_i.digits;
      NDIG_W'(4): aligned = {bcd_i.digits[15:0], 4'd0};
      NDIG_W'(3): aligned = {bcd_i.digits[11:0], 8'd0};
      NDIG_W'(2): aligned = {bcd_i.digits[7:0], 12'd0};
      default:    aligned = {bcd_i.digits[3:0], 16'd0};
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (bcd_valid_i) begin
          state_d = bcd_i.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (free) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (free && cnt_q == NDIG_W'(1)) begin
          state_d = ST_TAB;
        end
      end
      ST_TAB: begin
        if (free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    bcd_ready_o = 1'b0;
    emit        = 1'b0;
    shift       = 1'b0;
    emit_char   = CHAR_TAB;
    emit_last   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        bcd_ready_o = 1'b1;
      end
      ST_SIGN: begin
        emit      = free;
        emit_char = CHAR_MINUS;
      end
      ST_DIGIT: begin
        emit      = free;
        shift     = free;
        emit_char = CHAR_ZERO + {4'd0, dig_q[BCD_W-1 -: 4]};
      end
      ST_TAB: begin
        emit      = free;
        emit_char = CHAR_TAB;
        emit_last = 1'b1;
      end
      default: begin
        bcd_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    dig_d  = dig_q;
    cnt_d  = cnt_q;
    vld_d  = vld_q;
    char_d = char_q;
    last_d = last_q;
    if (take) begin
      dig_d = aligned;
      cnt_d = ndig;
    end else if (shift) begin
      dig_d = {dig_q[BCD_W-5:0], 4'd0};
      cnt_d = cnt_q - 1'b1;
    end
    if (emit) begin
      vld_d  = 1'b1;
      char_d = emit_char;
      last_d = emit_last;
    end else if (out_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  `SDAF_ASSERT(a_cnt_in_range, clk_i, rst_ni,
    (state_q == ST_DIGIT) |-> (cnt_q >= NDIG_W'(1) && cnt_q <= NDIG_W'(DIGITS)))
  `SDAF_ASSERT(a_digit_char, clk_i, rst_ni,
    (state_q == ST_DIGIT && free) |=> (char_q >= CHAR_ZERO && char_q <= CHAR_ZERO + 8'd9))
  `SDAF_ASSERT(a_last_is_tab, clk_i, rst_ni,
    (vld_q && last_q) |-> (char_q == CHAR_TAB))
  `SDAF_ASSERT(a_take_only_idle, clk_i, rst_ni,
    take |-> (state_q == ST_IDLE))

endmodule

// ----- rtl/signed_decimal_ascii_formatter.sv -----
// Top level of the signed decimal ASCII formatter.
// Depends on sdaf_pkg, sdaf_if, sdaf_bcd and sdaf_emit.
//
// Usage: each transaction on in_i carries one signed 16-bit value. The block
// answers on out_o with its decimal text, one ASCII character per transaction:
// a minus sign for negative values, the digits most significant first without
// leading zeros (zero gives a single '0'), and a closing tab with last set.
// -32768 is printed in full.
// The value is converted by a shift-and-add-three loop that takes one bit per
// cycle; once it is converted, the characters follow one per cycle while the
// receiver keeps up.
// The converter takes the next value while the emitter is still sending the
// previous one, so while the receiver keeps up the 16-step conversion loop
// sets the pace at which new values are accepted.
// Reset empties both stages and drops out_o.valid; nothing else is kept.
// When the receiver stalls, the presented character is held in the output
// register, the emitter waits, and once the converter has finished a value
// it holds in_i.ready low until the emitter takes that value.
module signed_decimal_ascii_formatter import sdaf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sdaf_in_if.sink     in_i,
  sdaf_out_if.source  out_o
);

  logic       bcd_valid;
  logic       bcd_ready;
  sdaf_bcd_t  bcd;

  // Bit-serial conversion of the magnitude into five BCD digits.
  sdaf_bcd u_bcd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .bcd_valid_o (bcd_valid),
    .bcd_ready_i (bcd_ready),
    .bcd_o       (bcd)
  );

  // Digit-serial character emission behind a registered output.
  sdaf_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bcd_valid_i (bcd_valid),
    .bcd_ready_o (bcd_ready),
    .bcd_i       (bcd),
    .out_o       (out_o)
  );

endmodule
